FILE: hw/rtl/tass_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tass_pkg
// Shared types and codes of the two-axis step sequencer.
// ---------------------------------------------------------------------------
package tass_pkg;

  // width of deltas, step totals and step counts
  localparam int STEP_WIDTH = 16;
  // width of the position fields of a block
  localparam int POS_WIDTH  = 16;
  localparam int LINE_WIDTH = 16;

  typedef logic [STEP_WIDTH-1:0] step_t;
  typedef logic [POS_WIDTH-1:0]  pos_t;

  // item kinds
  typedef enum logic [1:0] {
    KIND_BLOCK  = 2'd0,
    KIND_TICK_X = 2'd1,
    KIND_TICK_Y = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  // coordinate modes
  typedef enum logic [1:0] {
    COORD_ABS   = 2'd0,
    COORD_INC   = 2'd1,
    COORD_ZERO  = 2'd2,
    COORD_ZERO2 = 2'd3
  } coord_t;

  // motor step mode command
  typedef enum logic [1:0] {
    MODE_KEEP  = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_MICRO = 2'd2
  } step_mode_t;

  // step timer period select
  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_FULL  = 2'd1,
    SLOT_MICRO = 2'd2
  } slot_t;

  // per-axis status toward the top level
  typedef struct packed {
    logic       pulse_on;    // after this word
    logic       dir_pin;     // after this word
    logic       full_ready;  // current, for the other axis
    logic       busy;        // after this word
    logic       idle_tick;   // tick found nothing left
    step_mode_t mode_set;
    slot_t      slot;
  } axis_stat_t;

  // two's complement magnitude of a delta
  function automatic step_t step_mag(input step_t d);
    step_mag = d[STEP_WIDTH-1] ? step_t'(~d + step_t'(1)) : d;
  endfunction

endpackage : tass_pkg
`default_nettype wire

FILE: hw/rtl/two_axis_step_sequencer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_axis_step_sequencer_unit
// Motion block and step tick sequencer for two axes.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per event: a new motion
// block or a step timer tick of X or Y. Output channel (out_valid/out_ready)
// returns exactly one result word per input word, in order.
// Each word is captured in an input register, then the axis logic updates its
// state and fills the result register. One word per cycle is sustained while
// the receiver takes results; the rate is set by the single pass through the
// axis logic between those two registers.
// A block arriving while either axis is busy is dropped, but still yields a
// result word with all event fields low.
// When the receiver stalls the result register holds, the input register
// holds behind it, and in_ready falls once both are full.
// Reset clears all positions and counts, marks both axes idle and the block
// finished, and empties both registers.
// ---------------------------------------------------------------------------
module two_axis_step_sequencer_unit
  import tass_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   kind,
  input  wire logic [1:0]                   coord_mode,
  input  wire logic signed [POS_WIDTH-1:0]  pos_x_full,
  input  wire logic signed [POS_WIDTH-1:0]  pos_x_micro,
  input  wire logic signed [POS_WIDTH-1:0]  pos_y_full,
  input  wire logic signed [POS_WIDTH-1:0]  pos_y_micro,
  input  wire logic [LINE_WIDTH-1:0]        block_line,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              x_pulse_enable,
  output logic                              y_pulse_enable,
  output logic                              x_direction,
  output logic                              y_direction,
  output logic [1:0]                        step_mode_set,
  output logic [1:0]                        speed_slot,
  output logic                              timers_start,
  output logic                              line_report_valid,
  output logic [LINE_WIDTH-1:0]             line_report,
  output logic                              block_done
);

  // input register
  logic                   s1_valid;
  logic [1:0]             s1_kind;
  logic [1:0]             s1_mode;
  pos_t                   s1_xf, s1_xm, s1_yf, s1_ym;
  logic [LINE_WIDTH-1:0]  s1_line;
  logic                   s1_adv, s1_fire;

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_mode <= coord_mode;
      s1_xf   <= pos_x_full;
      s1_xm   <= pos_x_micro;
      s1_yf   <= pos_y_full;
      s1_ym   <= pos_y_micro;
      s1_line <= block_line;
    end
  end

  // sequencer state
  logic [1:0]            axis_idle, axis_idle_next;
  logic                  finished, finished_next;
  logic [LINE_WIDTH-1:0] high_line, high_line_next;
  logic                  load, tick_x, tick_y;
  logic                  start, lvalid, done;
  axis_stat_t            stat_x, stat_y;

  assign load   = s1_fire && (kind_t'(s1_kind) == KIND_BLOCK) && (axis_idle == 2'b11);
  assign tick_x = s1_fire && (kind_t'(s1_kind) == KIND_TICK_X);
  assign tick_y = s1_fire && (kind_t'(s1_kind) == KIND_TICK_Y);

  tass_axis u_axis_x (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .tick             (tick_x),
    .coord_mode       (s1_mode),
    .pos_full         (s1_xf),
    .pos_micro        (s1_xm),
    .other_full_ready (stat_y.full_ready),
    .stat             (stat_x)
  );

  tass_axis u_axis_y (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .tick             (tick_y),
    .coord_mode       (s1_mode),
    .pos_full         (s1_yf),
    .pos_micro        (s1_ym),
    .other_full_ready (stat_x.full_ready),
    .stat             (stat_y)
  );

  // block start, line report and completion
  always_comb begin
    axis_idle_next = axis_idle;
    finished_next  = finished;
    high_line_next = high_line;
    start          = 1'b0;
    lvalid         = 1'b0;
    done           = 1'b0;
    if (load) begin
      start          = 1'b1;
      finished_next  = 1'b0;
      axis_idle_next = {!stat_y.busy, !stat_x.busy};
      if (s1_line > high_line) begin
        high_line_next = s1_line;
        lvalid         = 1'b1;
      end
    end else if (stat_x.idle_tick || stat_y.idle_tick) begin
      axis_idle_next = axis_idle | {stat_y.idle_tick, stat_x.idle_tick};
      if (axis_idle_next == 2'b11 && !finished) begin
        finished_next = 1'b1;
        done          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_idle <= 2'b11;
      finished  <= 1'b1;
      high_line <= '0;
    end else begin
      axis_idle <= axis_idle_next;
      finished  <= finished_next;
      high_line <= high_line_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      x_pulse_enable    <= stat_x.pulse_on;
      y_pulse_enable    <= stat_y.pulse_on;
      x_direction       <= stat_x.dir_pin;
      y_direction       <= stat_y.dir_pin;
      step_mode_set     <= stat_x.mode_set | stat_y.mode_set;
      speed_slot        <= stat_x.slot | stat_y.slot;
      timers_start      <= start;
      line_report_valid <= lvalid;
      line_report       <= lvalid ? s1_line : '0;
      block_done        <= done;
    end
  end

endmodule : two_axis_step_sequencer_unit
`default_nettype wire

FILE: hw/rtl/tass_axis.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tass_axis
// State of one axis: block setup, full phase then micro phase, one step per
// timer tick.
// ---------------------------------------------------------------------------
module tass_axis
  import tass_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic                        tick,
  input  wire logic [1:0]                  coord_mode,
  input  wire logic signed [POS_WIDTH-1:0] pos_full,
  input  wire logic signed [POS_WIDTH-1:0] pos_micro,
  input  wire logic                        other_full_ready,
  output axis_stat_t                       stat
);

  pos_t  prev_pos, prev_pos_next;
  step_t full_total, full_total_next;
  step_t micro_total, micro_total_next;
  step_t full_count, full_count_next;
  step_t micro_count, micro_count_next;
  logic  dir_full, dir_full_next;
  logic  dir_micro, dir_micro_next;
  logic  dir_pin, dir_pin_next;
  logic  rdy_f, rdy_f_next, rdy_m, rdy_m_next;
  logic  pend_f, pend_f_next, pend_m, pend_m_next;

  logic signed [POS_WIDTH:0] diff_abs;
  step_t      df, dm;
  step_mode_t mode_set;
  slot_t      slot;
  logic       idle_tick;

  // deltas of a new block
  always_comb begin
    diff_abs = $signed({pos_full[POS_WIDTH-1], pos_full})
             - $signed({prev_pos[POS_WIDTH-1], prev_pos});
    unique case (coord_t'(coord_mode))
      COORD_ABS: begin
        df = step_t'(diff_abs);
        dm = step_t'(pos_micro);
      end
      COORD_INC: begin
        df = step_t'(pos_full);
        dm = step_t'(pos_micro);
      end
      default: begin
        df = '0;
        dm = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    prev_pos_next    = prev_pos;
    full_total_next  = full_total;
    micro_total_next = micro_total;
    full_count_next  = full_count;
    micro_count_next = micro_count;
    dir_full_next    = dir_full;
    dir_micro_next   = dir_micro;
    dir_pin_next     = dir_pin;
    rdy_f_next       = rdy_f;
    rdy_m_next       = rdy_m;
    pend_f_next      = pend_f;
    pend_m_next      = pend_m;
    mode_set         = MODE_KEEP;
    slot             = SLOT_NONE;
    idle_tick        = 1'b0;

    if (load) begin
      if (df != '0) begin
        full_total_next = step_mag(df);
        dir_full_next   = ~df[STEP_WIDTH-1];
        full_count_next = step_t'(1);
        rdy_f_next      = 1'b1;
        pend_f_next     = 1'b1;
        prev_pos_next   = pos_full;
      end
      if (dm != '0) begin
        micro_total_next = step_mag(dm);
        dir_micro_next   = ~dm[STEP_WIDTH-1];
        micro_count_next = step_t'(1);
        rdy_m_next       = 1'b1;
        pend_m_next      = 1'b1;
      end
    end else if (tick) begin
      priority if (rdy_f) begin
        if (pend_f) begin
          pend_f_next  = 1'b0;
          mode_set     = MODE_FULL;
          slot         = SLOT_FULL;
          dir_pin_next = dir_full;
        end
        if (full_count == full_total) rdy_f_next = 1'b0;
        else full_count_next = full_count + step_t'(1);
      end else if (rdy_m && !other_full_ready) begin
        if (pend_m) begin
          pend_m_next  = 1'b0;
          mode_set     = MODE_MICRO;
          slot         = SLOT_MICRO;
          dir_pin_next = dir_micro;
        end
        if (micro_count == micro_total) rdy_m_next = 1'b0;
        else micro_count_next = micro_count + step_t'(1);
      end else if (!rdy_m) begin
        idle_tick = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos    <= '0;
      full_total  <= '0;
      micro_total <= '0;
      full_count  <= '0;
      micro_count <= '0;
      dir_full    <= 1'b0;
      dir_micro   <= 1'b0;
      dir_pin     <= 1'b0;
      rdy_f       <= 1'b0;
      rdy_m       <= 1'b0;
      pend_f      <= 1'b0;
      pend_m      <= 1'b0;
    end else begin
      prev_pos    <= prev_pos_next;
      full_total  <= full_total_next;
      micro_total <= micro_total_next;
      full_count  <= full_count_next;
      micro_count <= micro_count_next;
      dir_full    <= dir_full_next;
      dir_micro   <= dir_micro_next;
      dir_pin     <= dir_pin_next;
      rdy_f       <= rdy_f_next;
      rdy_m       <= rdy_m_next;
      pend_f      <= pend_f_next;
      pend_m      <= pend_m_next;
    end
  end

  // status
  always_comb begin
    stat.pulse_on   = (rdy_f_next && !pend_f_next) || (rdy_m_next && !pend_m_next);
    stat.dir_pin    = dir_pin_next;
    stat.full_ready = rdy_f;
    stat.busy       = rdy_f_next || rdy_m_next;
    stat.idle_tick  = idle_tick;
    stat.mode_set   = mode_set;
    stat.slot       = slot;
  end

endmodule : tass_axis
`default_nettype wire

FILE: verif/two_axis_step_sequencer_unit_tb.sv
// ---------------------------------------------------------------------------
// two_axis_step_sequencer_unit_tb
// Self-checking bench for the two-axis step sequencer.
// A short table of blocks and ticks comes first: reset state, zero-motion
// blocks, an ignored busy block, and the order of full and micro phases.
// One run with no gaps and no stalls follows. After that come random motion
// blocks, each ticked out to completion, mixed with stray ticks, unused kinds
// and blocks sent while busy. An in-bench model of both axes predicts every
// result word. Both handshakes see random gaps.
// ---------------------------------------------------------------------------
module two_axis_step_sequencer_unit_tb;
  import tass_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t                 kind;
    coord_t                coord;
    pos_t                  x_full;
    pos_t                  x_micro;
    pos_t                  y_full;
    pos_t                  y_micro;
    logic [LINE_WIDTH-1:0] line_no;
  } seq_item_t;

  typedef struct packed {
    logic                  x_pe;
    logic                  y_pe;
    logic                  x_dir;
    logic                  y_dir;
    step_mode_t            mode_set;
    slot_t                 slot_sel;
    logic                  t_start;
    logic                  l_valid;
    logic [LINE_WIDTH-1:0] l_rep;
    logic                  done;
  } axis_status_t;

  typedef struct packed {
    seq_item_t    it;
    logic         fixed;
    axis_status_t res;
  } plan_row_t;

  localparam axis_status_t IDLE_STATUS = '0;
  localparam int RAND_WORDS = 700;

  // bench clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   kind = '0;
  logic [1:0]                   coord_mode = '0;
  logic signed [POS_WIDTH-1:0]  pos_x_full = '0;
  logic signed [POS_WIDTH-1:0]  pos_x_micro = '0;
  logic signed [POS_WIDTH-1:0]  pos_y_full = '0;
  logic signed [POS_WIDTH-1:0]  pos_y_micro = '0;
  logic [LINE_WIDTH-1:0]        block_line = '0;

  // output channel
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  x_pulse_enable;
  logic                  y_pulse_enable;
  logic                  x_direction;
  logic                  y_direction;
  logic [1:0]            step_mode_set;
  logic [1:0]            speed_slot;
  logic                  timers_start;
  logic                  line_report_valid;
  logic [LINE_WIDTH-1:0] line_report;
  logic                  block_done;

  two_axis_step_sequencer_unit DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .coord_mode        (coord_mode),
    .pos_x_full        (pos_x_full),
    .pos_x_micro       (pos_x_micro),
    .pos_y_full        (pos_y_full),
    .pos_y_micro       (pos_y_micro),
    .block_line        (block_line),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .x_pulse_enable    (x_pulse_enable),
    .y_pulse_enable    (y_pulse_enable),
    .x_direction       (x_direction),
    .y_direction       (y_direction),
    .step_mode_set     (step_mode_set),
    .speed_slot        (speed_slot),
    .timers_start      (timers_start),
    .line_report_valid (line_report_valid),
    .line_report       (line_report),
    .block_done        (block_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Axis model state (index 0 = X, 1 = Y)
  // ------------------------------------------------------------------
  pos_t                  prev_pos [2] = '{default: '0};
  step_t                 full_tot [2] = '{default: '0};
  step_t                 micro_tot [2] = '{default: '0};
  step_t                 full_cnt [2] = '{default: '0};
  step_t                 micro_cnt [2] = '{default: '0};
  logic                  dir_full [2] = '{default: 1'b0};
  logic                  dir_micro [2] = '{default: 1'b0};
  logic                  dir_pin [2] = '{default: 1'b0};
  // bit 0 X full, bit 1 X micro, bit 2 Y full, bit 3 Y micro
  logic [3:0]            phase_rdy = '0;
  logic [3:0]            phase_setup = '0;
  logic [1:0]            axes_idle = 2'b11;
  logic                  blk_finished = 1'b1;
  logic [LINE_WIDTH-1:0] high_line = '0;

  axis_status_t pin_status_q [$];
  int           err_cnt = 0;
  int           cyc = 0;
  int           stall_left = 0;
  logic         hurry = 1'b0;

  // arm one phase of an axis; a zero delta leaves it unarmed
  function automatic logic arm_phase(int a, logic is_micro, step_t d);
    step_t amount;
    logic  up;
    if (d == '0) return 1'b0;
    up = !d[STEP_WIDTH-1];
    amount = up ? d : step_t'(-d);
    if (is_micro) begin
      micro_tot[a] = amount;
      dir_micro[a] = up;
      micro_cnt[a] = step_t'(1);
    end else begin
      full_tot[a] = amount;
      dir_full[a] = up;
      full_cnt[a] = step_t'(1);
    end
    phase_rdy[2*a + int'(is_micro)] = 1'b1;
    phase_setup[2*a + int'(is_micro)] = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic pulse_live(int a);
    return (phase_rdy[2*a] && !phase_setup[2*a]) ||
           (phase_rdy[2*a+1] && !phase_setup[2*a+1]);
  endfunction

  // apply one accepted word to the axis model, return its status word
  function automatic axis_status_t advance_axes(seq_item_t it);
    axis_status_t r;
    pos_t         full_f;
    pos_t         micro_f;
    step_t        df;
    step_t        dm;
    int           a;
    int           fb;
    int           mb;
    int           ofb;
    r = IDLE_STATUS;
    if (it.kind == KIND_BLOCK) begin
      // a block is taken only with both axes idle
      if (axes_idle == 2'b11) begin
        blk_finished = 1'b0;
        r.t_start = 1'b1;
        if (it.line_no > high_line) begin
          high_line = it.line_no;
          r.l_valid = 1'b1;
          r.l_rep = it.line_no;
        end
        for (a = 0; a < 2; a++) begin
          full_f  = (a == 0) ? it.x_full : it.y_full;
          micro_f = (a == 0) ? it.x_micro : it.y_micro;
          df = '0;
          dm = '0;
          if (it.coord == COORD_ABS) begin
            df = step_t'(signed'(full_f)) - step_t'(signed'(prev_pos[a]));
            dm = step_t'(signed'(micro_f));
          end else if (it.coord == COORD_INC) begin
            df = step_t'(signed'(full_f));
            dm = step_t'(signed'(micro_f));
          end
          if (arm_phase(a, 1'b0, df)) prev_pos[a] = full_f;
          void'(arm_phase(a, 1'b1, dm));
          if (phase_rdy[2*a +: 2] != 2'b00) axes_idle[a] = 1'b0;
        end
      end
    end else if (it.kind == KIND_TICK_X || it.kind == KIND_TICK_Y) begin
      a   = (it.kind == KIND_TICK_X) ? 0 : 1;
      fb  = 2*a;
      mb  = 2*a + 1;
      ofb = 2*(1 - a);
      if (phase_rdy[fb]) begin
        // full steps first
        if (phase_setup[fb]) begin
          phase_setup[fb] = 1'b0;
          r.mode_set = MODE_FULL;
          r.slot_sel = SLOT_FULL;
          dir_pin[a] = dir_full[a];
        end
        if (full_cnt[a] == full_tot[a]) phase_rdy[fb] = 1'b0;
        else full_cnt[a] = full_cnt[a] + step_t'(1);
      end else if (phase_rdy[mb] && !phase_rdy[ofb]) begin
        // micro steps wait on the other axis's full steps
        if (phase_setup[mb]) begin
          phase_setup[mb] = 1'b0;
          r.mode_set = MODE_MICRO;
          r.slot_sel = SLOT_MICRO;
          dir_pin[a] = dir_micro[a];
        end
        if (micro_cnt[a] == micro_tot[a]) phase_rdy[mb] = 1'b0;
        else micro_cnt[a] = micro_cnt[a] + step_t'(1);
      end else if (!phase_rdy[fb] && !phase_rdy[mb]) begin
        axes_idle[a] = 1'b1;
        if (axes_idle == 2'b11 && !blk_finished) begin
          blk_finished = 1'b1;
          r.done = 1'b1;
        end
      end
    end
    r.x_pe  = pulse_live(0);
    r.y_pe  = pulse_live(1);
    r.x_dir = dir_pin[0];
    r.y_dir = dir_pin[1];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic seq_item_t mk_item(kind_t k, coord_t m, int xf, int xm,
                                        int yf, int ym, int ln);
    seq_item_t it;
    it.kind    = k;
    it.coord   = m;
    it.x_full  = pos_t'(xf);
    it.x_micro = pos_t'(xm);
    it.y_full  = pos_t'(yf);
    it.y_micro = pos_t'(ym);
    it.line_no = LINE_WIDTH'(ln);
    return it;
  endfunction

  function automatic axis_status_t mk_status(logic ts, logic lv, int lr, logic dn);
    axis_status_t r;
    r = IDLE_STATUS;
    r.t_start = ts;
    r.l_valid = lv;
    r.l_rep   = LINE_WIDTH'(lr);
    r.done    = dn;
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic calm_now();
    return hurry || ((cyc / 300) % 4 == 0);
  endfunction

  function automatic int pick_delta();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    mag = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  function automatic seq_item_t rand_payload(kind_t k);
    seq_item_t it;
    it.kind    = k;
    it.coord   = coord_t'($urandom_range(0, 3));
    it.x_full  = pos_t'($urandom);
    it.x_micro = pos_t'($urandom);
    it.y_full  = pos_t'($urandom);
    it.y_micro = pos_t'($urandom);
    it.line_no = LINE_WIDTH'($urandom);
    return it;
  endfunction

  // motion block with short moves; zero modes carry any field values
  function automatic seq_item_t motion_block();
    seq_item_t it;
    int        r;
    int        nl;
    it = rand_payload(KIND_BLOCK);
    r = $urandom_range(0, 99);
    it.coord = (r < 45) ? COORD_ABS : (r < 85) ? COORD_INC :
               (r < 95) ? COORD_ZERO : COORD_ZERO2;
    if (it.coord == COORD_ABS) begin
      it.x_full = prev_pos[0] + pos_t'(pick_delta());
      it.y_full = prev_pos[1] + pos_t'(pick_delta());
    end else if (it.coord == COORD_INC) begin
      it.x_full = pos_t'(pick_delta());
      it.y_full = pos_t'(pick_delta());
    end
    if (it.coord == COORD_ABS || it.coord == COORD_INC) begin
      it.x_micro = pos_t'(pick_delta());
      it.y_micro = pos_t'(pick_delta());
    end
    // line numbers mostly climb so that reports keep coming
    if ($urandom_range(0, 99) < 75) begin
      nl = int'(high_line) + $urandom_range(0, 400);
      it.line_no = (nl > 16'hFFFE) ? 16'hFFFE : LINE_WIDTH'(nl);
    end else begin
      it.line_no = LINE_WIDTH'($urandom_range(0, int'(high_line)));
    end
    return it;
  endfunction

  // the axis tick that makes progress in the current state
  function automatic kind_t useful_tick();
    if (phase_rdy[0]) return KIND_TICK_X;
    if (phase_rdy[2]) return KIND_TICK_Y;
    if (phase_rdy[1]) return KIND_TICK_X;
    if (phase_rdy[3]) return KIND_TICK_Y;
    if (!axes_idle[0]) return KIND_TICK_X;
    if (!axes_idle[1]) return KIND_TICK_Y;
    return $urandom_range(0, 1) ? KIND_TICK_X : KIND_TICK_Y;
  endfunction

  // offer one word, hold it until taken, then log its expected status
  task automatic send_word(seq_item_t it, logic use_fixed = 1'b0,
                           axis_status_t fixed_res = IDLE_STATUS);
    int           gap;
    axis_status_t r;
    gap = (calm_now() || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind        <= it.kind;
    coord_mode  <= it.coord;
    pos_x_full  <= it.x_full;
    pos_x_micro <= it.x_micro;
    pos_y_full  <= it.y_full;
    pos_y_micro <= it.y_micro;
    block_line  <= it.line_no;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_axes(it);
    pin_status_q.push_back(use_fixed ? fixed_res : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_status_q.size() != 0);
  endtask

  // send a block, then tick it out with some noise mixed in
  task automatic run_block(seq_item_t blk, inout int counted);
    seq_item_t it;
    int        r;
    send_word(blk);
    counted++;
    while (!blk_finished) begin
      r = $urandom_range(0, 99);
      if (r < 5 && axes_idle != 2'b11) begin
        send_word(rand_payload(KIND_BLOCK));
      end else if (r < 8) begin
        send_word(rand_payload(KIND_NOP));
      end else begin
        it = rand_payload(KIND_TICK_X);
        it.kind = (r < 16) ? kind_t'($urandom_range(1, 2)) : useful_tick();
        send_word(it);
        counted++;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];
    int        counted;
    int        seq_n;
    int        r;
    counted = 0;
    seq_n = 0;

    // reset state, zero-motion blocks, phase ordering, busy and wrap cases
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b1, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_NOP, COORD_INC, 32767, -32768, 32767, -32768, 65535),
                     1'b1, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_BLOCK, COORD_ZERO, -32768, 32767, 32767, -32768, 0),
                     1'b1, mk_status(1'b1, 1'b0, 0, 1'b0)});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0),
                     1'b1, mk_status(1'b0, 1'b0, 0, 1'b1)});
    plan.push_back('{mk_item(KIND_BLOCK, COORD_ZERO2, -1, -1, -1, -1, 1),
                     1'b1, mk_status(1'b1, 1'b1, 1, 1'b0)});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0),
                     1'b1, mk_status(1'b0, 1'b0, 0, 1'b1)});
    plan.push_back('{mk_item(KIND_BLOCK, COORD_INC, 2, -1, 0, 1, 5), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_BLOCK, COORD_ABS, 7, 7, 7, 7, 100), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    // absolute target equal to the last position: no X motion
    plan.push_back('{mk_item(KIND_BLOCK, COORD_ABS, 2, 0, -3, 0, 4), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_X, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});
    plan.push_back('{mk_item(KIND_TICK_Y, COORD_ABS, 0, 0, 0, 0, 0), 1'b0, IDLE_STATUS});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i].it, plan[i].fixed, plan[i].res);
    wait_drained();

    // back-to-back run: negative full X steps, then positive micro Y steps
    hurry = 1'b1;
    run_block(mk_item(KIND_BLOCK, COORD_INC, -40, 0, 0, 40, 200), counted);
    hurry = 1'b0;

    // random blocks, each run to completion
    counted = 0;
    while (counted < RAND_WORDS) begin
      seq_n++;
      if (seq_n % 10 == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) send_word(rand_payload(kind_t'($urandom_range(1, 2))));
      else if (r < 9) send_word(rand_payload(KIND_NOP));
      run_block(motion_block(), counted);
    end

    // highest line number last, since reports never go back down
    run_block(mk_item(KIND_BLOCK, COORD_INC, 3, -2, -1, 2, 65535), counted);

    in_valid <= 1'b0;
    do @(posedge clk); while (pin_status_q.size() != 0);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // receiver with random stalls
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm_now() && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------
  task automatic log_error(string msg);
    if (err_cnt < 50) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp);
    if (got !== exp) log_error($sformatf("%s got %0h exp %0h", name, got, exp));
  endtask

  always @(posedge clk) begin
    axis_status_t exp;
    if (!rst && out_valid && out_ready) begin
      if (pin_status_q.size() == 0) begin
        log_error("result word with nothing expected");
      end else begin
        exp = pin_status_q.pop_front();
        check_field("x_pulse_enable", 16'(x_pulse_enable), 16'(exp.x_pe));
        check_field("y_pulse_enable", 16'(y_pulse_enable), 16'(exp.y_pe));
        check_field("x_direction", 16'(x_direction), 16'(exp.x_dir));
        check_field("y_direction", 16'(y_direction), 16'(exp.y_dir));
        check_field("step_mode_set", 16'(step_mode_set), 16'(exp.mode_set));
        check_field("speed_slot", 16'(speed_slot), 16'(exp.slot_sel));
        check_field("timers_start", 16'(timers_start), 16'(exp.t_start));
        check_field("line_report_valid", 16'(line_report_valid), 16'(exp.l_valid));
        check_field("line_report", line_report, exp.l_rep);
        check_field("block_done", 16'(block_done), 16'(exp.done));
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tass_pkg.sv
hw/rtl/tass_axis.sv
hw/rtl/two_axis_step_sequencer_unit.sv
verif/two_axis_step_sequencer_unit_tb.sv
